// File: src/lcprcd_pkg.sv
// Package: shared widths, register indexes and item types of the LCP run cluster detector.
`timescale 1ns / 1ps

package lcprcd_pkg;

    // Field widths
    localparam int LCP_W  = 16;
    localparam int SEQ_W  = 32;
    localparam int POS_W  = 40;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 1;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] REG_MIN_LCP    = 1'd0;
    localparam logic [ADDR_W-1:0] REG_READ_COUNT = 1'd1;

    // Input item
    typedef struct packed {
        logic [LCP_W-1:0] lcp_value;
        logic [SEQ_W-1:0] doc_id;
        logic             last_position;
    } lcprcd_in_t;

    // Result item
    typedef struct packed {
        logic [POS_W-1:0] cluster_start;
        logic [POS_W-1:0] cluster_length;
        logic             cluster_valid;
        logic [POS_W-1:0] max_length;
        logic [POS_W-1:0] cluster_total;
        logic             stream_done;
    } lcprcd_out_t;

    // Configuration seen by the front end
    typedef struct packed {
        logic [LCP_W-1:0] min_lcp;
        logic [SEQ_W-1:0] read_count;
    } lcprcd_cfg_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic lcp_ge;     // LCP at or above threshold
        logic cur_read;   // this position's document is a read
        logic prev_read;  // previous position's document is a read
        logic last;       // final position of the stream
    } lcprcd_entry_t;

endpackage

// File: src/lcprcd_front.sv
// Front end: accepts input items and classifies them against the threshold and read count.
`timescale 1ns / 1ps

module lcprcd_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lcprcd_pkg::lcprcd_cfg_t cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  lcprcd_pkg::lcprcd_in_t  s_data,
    output logic                    push,
    output lcprcd_pkg::lcprcd_entry_t push_entry,
    input  logic                    q_full
);

    logic [lcprcd_pkg::SEQ_W-1:0] prev_doc_reg;
    logic [lcprcd_pkg::SEQ_W-1:0] prev_doc_next;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // Classify the item; the previous document id is classified here as well
    always_comb begin
        push_entry.lcp_ge    = (s_data.lcp_value >= cfg.min_lcp);
        push_entry.cur_read  = (s_data.doc_id < cfg.read_count);
        push_entry.prev_read = (prev_doc_reg < cfg.read_count);
        push_entry.last      = s_data.last_position;
    end

    // Previous document id, back to zero after the last position
    always_comb begin
        prev_doc_next = prev_doc_reg;
        if (push) begin
            prev_doc_next = s_data.last_position ? '0 : s_data.doc_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_doc_reg <= '0;
        end else begin
            prev_doc_reg <= prev_doc_next;
        end
    end

endmodule

// File: src/lcprcd_queue.sv
// Two-entry queue of classified items between front and back.
`timescale 1ns / 1ps

module lcprcd_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  lcprcd_pkg::lcprcd_entry_t push_entry,
    output logic                      full,
    input  logic                      pop,
    output logic                      q_valid,
    output lcprcd_pkg::lcprcd_entry_t q_entry
);

    lcprcd_pkg::lcprcd_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/lcprcd_back.sv
// Back end: cluster state, reporting and the result register.
`timescale 1ns / 1ps

module lcprcd_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  lcprcd_pkg::lcprcd_entry_t q_entry,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lcprcd_pkg::lcprcd_out_t   m_data
);

    localparam int PW = lcprcd_pkg::POS_W;

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] start_reg, start_next;
    logic [PW-1:0] longest_reg, longest_next;
    logic [PW-1:0] count_reg, count_next;
    logic          open_reg, open_next;
    logic          has_read_reg, has_read_next;
    logic          has_genome_reg, has_genome_next;
    logic          m_valid_reg, m_valid_next;
    lcprcd_pkg::lcprcd_out_t m_data_reg, m_data_next;

    logic [PW-1:0] start1, rep_start, rep_end, rep_len, longest_upd, count_upd;
    logic          hr1, hg1, rep, emit;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pop     = q_valid && (!m_valid_reg || m_ready);

    // Per-item cluster update
    always_comb begin
        if (q_entry.lcp_ge) begin
            hr1 = has_read_reg | (!open_reg & q_entry.prev_read) | q_entry.cur_read;
            hg1 = has_genome_reg | (!open_reg & !q_entry.prev_read) | !q_entry.cur_read;
            if (open_reg) begin
                start1 = start_reg;
            end else begin
                start1 = (pos_reg == '0) ? '0 : pos_reg - PW'(1);
            end
            rep       = q_entry.last & hr1 & hg1;
            rep_start = start1;
            rep_end   = pos_reg + PW'(1);
        end else begin
            hr1       = 1'b0;
            hg1       = 1'b0;
            start1    = '0;
            rep       = open_reg & has_read_reg & has_genome_reg;
            rep_start = start_reg;
            rep_end   = pos_reg;
        end
        rep_len     = rep_end - rep_start;
        longest_upd = (rep && (rep_len > longest_reg)) ? rep_len : longest_reg;
        count_upd   = rep ? count_reg + PW'(1) : count_reg;
        emit        = rep | q_entry.last;
    end

    // State and result register
    always_comb begin
        pos_next        = pos_reg;
        start_next      = start_reg;
        longest_next    = longest_reg;
        count_next      = count_reg;
        open_next       = open_reg;
        has_read_next   = has_read_reg;
        has_genome_next = has_genome_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        if (pop) begin
            if (q_entry.last) begin
                pos_next        = '0;
                start_next      = '0;
                longest_next    = '0;
                count_next      = '0;
                open_next       = 1'b0;
                has_read_next   = 1'b0;
                has_genome_next = 1'b0;
            end else begin
                pos_next        = pos_reg + PW'(1);
                start_next      = start1;
                longest_next    = longest_upd;
                count_next      = count_upd;
                open_next       = q_entry.lcp_ge;
                has_read_next   = hr1;
                has_genome_next = hg1;
            end
            if (emit) begin
                m_valid_next               = 1'b1;
                m_data_next.cluster_start  = rep ? rep_start : '0;
                m_data_next.cluster_length = rep ? rep_len : '0;
                m_data_next.cluster_valid  = rep;
                m_data_next.max_length     = longest_upd;
                m_data_next.cluster_total  = count_upd;
                m_data_next.stream_done    = q_entry.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            start_reg      <= '0;
            longest_reg    <= '0;
            count_reg      <= '0;
            open_reg       <= 1'b0;
            has_read_reg   <= 1'b0;
            has_genome_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            start_reg      <= start_next;
            longest_reg    <= longest_next;
            count_reg      <= count_next;
            open_reg       <= open_next;
            has_read_reg   <= has_read_next;
            has_genome_reg <= has_genome_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // Stream end returns the cluster state to its start
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_entry.last) |=> (pos_reg == '0 && !open_reg && count_reg == '0))
        else $error("stream state not cleared after last item");

    // Content flags only while a cluster is open
    a_flags_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !open_reg |-> (!has_read_reg && !has_genome_reg))
        else $error("read/genome flag set with no open cluster");

    // A bare end report carries no cluster
    a_bare_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.cluster_valid) |->
        (m_data_reg.stream_done && m_data_reg.cluster_start == '0 &&
         m_data_reg.cluster_length == '0))
        else $error("result without cluster is not a clean end report");

    // Reported length never exceeds the running maximum
    a_max_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.cluster_valid) |->
        (m_data_reg.max_length >= m_data_reg.cluster_length &&
         m_data_reg.cluster_total != '0))
        else $error("cluster length above max or total is zero");

    // A stalled result is held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("result changed while stalled");

endmodule

// File: src/lcp_run_cluster_detector_unit.sv
// Top level: LCP run cluster detector with configuration registers.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one position of the sorted
//   suffix list per item (LCP value, document id, last-position flag).
//   Result channel m_valid/m_ready/m_data carries at most one result per
//   item: a qualifying cluster when a run closes, and always one result on
//   the last position, flagged stream_done.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr
//   (min_lcp, read_count); write only while no item is in flight.
// Flow:
//   An accepted item passes through the queue, and its result is captured in
//   the back end's result register. Throughput is one item per cycle while
//   m_ready is high, set by the combinational cluster update in the back end.
//   A two-entry queue between the classifying front end and the back end, and
//   the result register, let the input keep flowing while a result waits.
// Reset:
//   aresetn (synchronous, active low) clears the stream state, queue, configuration
//   registers and result valid flag. When m_ready is low, the held result stalls the back end, the
//   queue fills, and s_ready falls after at most two more items.
`timescale 1ns / 1ps

module lcp_run_cluster_detector_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lcprcd_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [lcprcd_pkg::DATA_W-1:0]      cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lcprcd_pkg::lcprcd_in_t             s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lcprcd_pkg::lcprcd_out_t            m_data
);

    lcprcd_pkg::lcprcd_cfg_t   cfg_reg, cfg_next;
    lcprcd_pkg::lcprcd_entry_t push_entry, q_entry;
    logic push, q_full, pop, q_valid;

    // Configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                lcprcd_pkg::REG_MIN_LCP: begin
                    cfg_next.min_lcp = cfg_wdata[lcprcd_pkg::LCP_W-1:0];
                end
                lcprcd_pkg::REG_READ_COUNT: begin
                    cfg_next.read_count = cfg_wdata[lcprcd_pkg::SEQ_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcprcd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    lcprcd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    lcprcd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
